// File: rtl/core/s2es_pkg.sv
// Shared types and constants of the symmetric 2x2 eigen solver.
`default_nettype none
package s2es_pkg;
	localparam int CHOP_W = 5;
	localparam logic [CHOP_W-1:0] CHOP_RESET = 5'd23;
	localparam int EIG_W = 34;
	localparam int VEC_W = 32;
	localparam int FRAC_W = 30;
	localparam int NRM_W = 31;
	localparam int ROOT_W = NRM_W + 1;
	localparam int QUO_W = NRM_W;
	localparam logic signed [VEC_W-1:0] ONE_Q30 = 32'sd1073741824;

	typedef logic signed [EIG_W-1:0] eig_t;
	typedef logic signed [VEC_W-1:0] vec_t;
endpackage
`default_nettype wire

// File: rtl/core/s2es_mat_if.sv
// Input channel: one symmetric matrix per transaction.
`default_nettype none
interface s2es_mat_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] a11;
	logic signed [DATA_WIDTH-1:0] a12;
	logic signed [DATA_WIDTH-1:0] a22;
	modport source(output valid, output a11, output a12, output a22, input ready);
	modport sink(input valid, input a11, input a12, input a22, output ready);
endinterface
`default_nettype wire

// File: rtl/core/s2es_eig_if.sv
// Output channel: eigenvalues and eigenvector matrix per transaction.
`default_nettype none
interface s2es_eig_if;
	logic valid;
	logic ready;
	s2es_pkg::eig_t eig_first;
	s2es_pkg::eig_t eig_second;
	s2es_pkg::vec_t vec_11;
	s2es_pkg::vec_t vec_12;
	s2es_pkg::vec_t vec_21;
	s2es_pkg::vec_t vec_22;
	modport source(output valid, output eig_first, output eig_second, output vec_11,
		output vec_12, output vec_21, output vec_22, input ready);
	modport sink(input valid, input eig_first, input eig_second, input vec_11,
		input vec_12, input vec_21, input vec_22, output ready);
endinterface
`default_nettype wire

// File: rtl/core/symmetric_2x2_eigen_solver.sv
// Symmetric 2x2 eigen solver: shifted Givens rotation, fully pipelined.
// Its stages include the two square-root pipelines (one root bit per stage)
// and the divider (one quotient bit per stage).
// Throughput: one matrix per cycle; the whole pipeline holds while a result waits.
// Reset: arst_n clears all valid bits and loads chop_q with 23.
`default_nettype none
module symmetric_2x2_eigen_solver #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [s2es_pkg::CHOP_W-1:0]   cfg_wdata,
	s2es_mat_if.sink                      mat,
	s2es_eig_if.source                    eig
);
	localparam int W = DATA_WIDTH;
	localparam int RA_W = 2 * W + 2;
	localparam int HR_W = RA_W / 2;
	localparam int MU_W = W + 3;
	localparam int LIM_W = W + 1;
	localparam int LSH_W = LIM_W + 32;
	localparam int XW = W + 4;
	localparam int AX_W = W + 3;
	localparam int SH_W = $clog2(AX_W + 1);
	localparam int NW = s2es_pkg::NRM_W;
	localparam int RB_W = 2 * s2es_pkg::ROOT_W;
	localparam int QW = s2es_pkg::QUO_W;
	localparam int DV_W = QW + s2es_pkg::ROOT_W - 1;
	localparam int VW = s2es_pkg::VEC_W;
	localparam int FR = s2es_pkg::FRAC_W;
	localparam int PW = VW + W;
	localparam int FW = PW + 2;
	localparam int LX = FW - FR + s2es_pkg::EIG_W;
	localparam int TA_W = 3 * W + 1;
	localparam int TB_W = 3 * W + 3 + 2 * NW;
	localparam int TD_W = 3 * W + 3;
	localparam logic signed [2*VW-1:0] RND_P = (2*VW)'(64'sd1 <<< (FR - 1));
	localparam logic signed [FW-1:0] RND_F = FW'(64'sd1 <<< (FR - 1));
	localparam logic signed [LX-1:0] EMAX = LX'((64'sd1 <<< (s2es_pkg::EIG_W - 1)) - 64'sd1);
	localparam logic signed [LX-1:0] EMIN = LX'(-(64'sd1 <<< (s2es_pkg::EIG_W - 1)));

	logic [s2es_pkg::CHOP_W-1:0] chop_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chop_q <= s2es_pkg::CHOP_RESET;
		end else if (cfg_we) begin
			chop_q <= cfg_wdata;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14, v_s15, v_s16, v_s17;
	logic va, vb, vd;

	assign en = !v_s17 || eig.ready;
	assign mat.ready = en;

	// stage 1: chop test and difference
	logic [W-1:0] m11, m12, m22;
	logic [W:0] dsum, dm;
	logic signed [W:0] d1;
	logic [W+30:0] absh;
	logic chop;
	logic signed [W-1:0] a11_s1, a12_s1, a22_s1;
	logic [W-1:0] ad_s1, ab_s1;
	logic rot_s1;

	always_comb begin
		m11 = mat.a11[W-1] ? (~mat.a11 + 1'b1) : mat.a11;
		m12 = mat.a12[W-1] ? (~mat.a12 + 1'b1) : mat.a12;
		m22 = mat.a22[W-1] ? (~mat.a22 + 1'b1) : mat.a22;
		dsum = {1'b0, m11} + {1'b0, m22};
		absh = (W+31)'(m12) << chop_q;
		chop = absh < (W+31)'(dsum);
		d1 = (W+1)'(mat.a11) - (W+1)'(mat.a22);
		dm = d1[W] ? (~d1 + 1'b1) : d1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a11_s1 <= mat.a11;
			a12_s1 <= chop ? '0 : mat.a12;
			a22_s1 <= mat.a22;
			ad_s1 <= dm[W-1:0];
			ab_s1 <= chop ? '0 : m12;
			rot_s1 <= !chop && (mat.a12 != '0);
		end
	end

	// stage 2: squares
	logic [2*W-1:0] dsq_s2, absq_s2;
	logic signed [W-1:0] a11_s2, a12_s2, a22_s2;
	logic rot_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			dsq_s2 <= ad_s1 * ad_s1;
			absq_s2 <= ab_s1 * ab_s1;
			a11_s2 <= a11_s1;
			a12_s2 <= a12_s1;
			a22_s2 <= a22_s1;
			rot_s2 <= rot_s1;
		end
	end

	// stage 3: d^2 + 4*a12^2
	logic [RA_W-1:0] rad_s3;
	logic signed [W-1:0] a11_s3, a12_s3, a22_s3;
	logic rot_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= RA_W'(dsq_s2) + (RA_W'(absq_s2) << 2);
			a11_s3 <= a11_s2;
			a12_s3 <= a12_s2;
			a22_s3 <= a22_s2;
			rot_s3 <= rot_s2;
		end
	end

	logic [HR_W-1:0] hyp;
	logic [TA_W-1:0] ta_out;
	logic signed [W-1:0] a11_a, a12_a, a22_a;
	logic rot_a;

	s2es_isqrt_pipe #(.RAD_W(RA_W), .TAG_W(TA_W)) u_hyp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3), .rad(rad_s3),
		.tag_in({rot_s3, a11_s3, a12_s3, a22_s3}),
		.out_valid(va), .root(hyp), .tag_out(ta_out)
	);
	assign {rot_a, a11_a, a12_a, a22_a} = ta_out;

	// stage 4: Wilkinson shift (doubled) and cancel limit
	logic signed [W:0] d4;
	logic signed [MU_W-1:0] hx, mu4;
	logic [W-1:0] n11, n12;
	logic signed [MU_W-1:0] mu2_s4;
	logic [LIM_W-1:0] lim_s4;
	logic signed [W-1:0] a11_s4, a12_s4, a22_s4;
	logic rot_s4;

	always_comb begin
		d4 = (W+1)'(a11_a) - (W+1)'(a22_a);
		hx = $signed(MU_W'(hyp));
		mu4 = (MU_W'(a22_a) <<< 1) + MU_W'(d4) + (d4[W] ? hx : -hx);
		n11 = a11_a[W-1] ? (~a11_a + 1'b1) : a11_a;
		n12 = a12_a[W-1] ? (~a12_a + 1'b1) : a12_a;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mu2_s4 <= mu4;
			lim_s4 <= {1'b0, n11} + {1'b0, n12};
			a11_s4 <= a11_a;
			a12_s4 <= a12_a;
			a22_s4 <= a22_a;
			rot_s4 <= rot_a;
		end
	end

	// stage 5: drop the shift when it is far too large
	logic [MU_W-1:0] amu;
	logic [LSH_W-1:0] limsh;
	logic signed [MU_W-1:0] mu2_s5;
	logic signed [W-1:0] a11_s5, a12_s5, a22_s5;
	logic rot_s5;

	always_comb begin
		amu = mu2_s4[MU_W-1] ? (~mu2_s4 + 1'b1) : mu2_s4;
		limsh = LSH_W'(lim_s4) << ({1'b0, chop_q} + 6'd1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mu2_s5 <= (LSH_W'(amu) > limsh) ? '0 : mu2_s4;
			a11_s5 <= a11_s4;
			a12_s5 <= a12_s4;
			a22_s5 <= a22_s4;
			rot_s5 <= rot_s4;
		end
	end

	// stage 6: rotation operands
	logic signed [XW-1:0] xx;
	logic signed [W:0] zz;
	logic [XW-1:0] axw;
	logic [W:0] azw;
	logic [AX_W-1:0] ax_s6, az_s6;
	logic neg_s6;
	logic signed [W-1:0] a11_s6, a12_s6, a22_s6;
	logic rot_s6;

	always_comb begin
		xx = (XW'(a11_s5) <<< 1) - XW'(mu2_s5);
		zz = (W+1)'(a12_s5) <<< 1;
		axw = xx[XW-1] ? (~xx + 1'b1) : xx;
		azw = zz[W] ? (~zz + 1'b1) : zz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s6 <= axw[AX_W-1:0];
			az_s6 <= AX_W'(azw);
			neg_s6 <= xx[XW-1] != zz[W];
			a11_s6 <= a11_s5;
			a12_s6 <= a12_s5;
			a22_s6 <= a22_s5;
			rot_s6 <= rot_s5;
		end
	end

	// stage 7: normalize shift count
	logic [AX_W-1:0] orv;
	logic [SH_W-1:0] bl, sh;
	logic [SH_W-1:0] sh_s7;
	logic [AX_W-1:0] ax_s7, az_s7;
	logic neg_s7, swp_s7;
	logic signed [W-1:0] a11_s7, a12_s7, a22_s7;
	logic rot_s7;

	always_comb begin
		orv = ax_s6 | az_s6;
		bl = '0;
		for (int i = 0; i < AX_W; i++) begin
			if (orv[i]) begin
				bl = SH_W'(i + 1);
			end
		end
		sh = '0;
		if (int'(bl) > NW) begin
			sh = SH_W'(int'(bl) - NW);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s7 <= sh;
			ax_s7 <= ax_s6;
			az_s7 <= az_s6;
			neg_s7 <= neg_s6;
			swp_s7 <= az_s6 > ax_s6;
			a11_s7 <= a11_s6;
			a12_s7 <= a12_s6;
			a22_s7 <= a22_s6;
			rot_s7 <= rot_s6;
		end
	end

	// stage 8: normalize
	logic [NW-1:0] nx_s8, nz_s8;
	logic neg_s8, swp_s8;
	logic signed [W-1:0] a11_s8, a12_s8, a22_s8;
	logic rot_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s8 <= NW'(ax_s7 >> sh_s7);
			nz_s8 <= NW'(az_s7 >> sh_s7);
			neg_s8 <= neg_s7;
			swp_s8 <= swp_s7;
			a11_s8 <= a11_s7;
			a12_s8 <= a12_s7;
			a22_s8 <= a22_s7;
			rot_s8 <= rot_s7;
		end
	end

	// stage 9: squares
	logic [2*NW-1:0] nx2_s9, nz2_s9;
	logic [NW-1:0] nx_s9, nz_s9;
	logic neg_s9, swp_s9;
	logic signed [W-1:0] a11_s9, a12_s9, a22_s9;
	logic rot_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			nx2_s9 <= nx_s8 * nx_s8;
			nz2_s9 <= nz_s8 * nz_s8;
			nx_s9 <= nx_s8;
			nz_s9 <= nz_s8;
			neg_s9 <= neg_s8;
			swp_s9 <= swp_s8;
			a11_s9 <= a11_s8;
			a12_s9 <= a12_s8;
			a22_s9 <= a22_s8;
			rot_s9 <= rot_s8;
		end
	end

	// stage 10: norm squared
	logic [RB_W-1:0] rb_s10;
	logic [NW-1:0] nx_s10, nz_s10;
	logic neg_s10, swp_s10;
	logic signed [W-1:0] a11_s10, a12_s10, a22_s10;
	logic rot_s10;
	always_ff @(posedge clk) begin
		if (en) begin
			rb_s10 <= RB_W'(nx2_s9) + RB_W'(nz2_s9);
			nx_s10 <= nx_s9;
			nz_s10 <= nz_s9;
			neg_s10 <= neg_s9;
			swp_s10 <= swp_s9;
			a11_s10 <= a11_s9;
			a12_s10 <= a12_s9;
			a22_s10 <= a22_s9;
			rot_s10 <= rot_s9;
		end
	end

	logic [s2es_pkg::ROOT_W-1:0] rnorm;
	logic [TB_W-1:0] tb_out;
	logic [NW-1:0] nx_b, nz_b;
	logic neg_b, swp_b, rot_b;
	logic signed [W-1:0] a11_b, a12_b, a22_b;

	s2es_isqrt_pipe #(.RAD_W(RB_W), .TAG_W(TB_W)) u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s10), .rad(rb_s10),
		.tag_in({rot_s10, neg_s10, swp_s10, nx_s10, nz_s10, a11_s10, a12_s10, a22_s10}),
		.out_valid(vb), .root(rnorm), .tag_out(tb_out)
	);
	assign {rot_b, neg_b, swp_b, nx_b, nz_b, a11_b, a12_b, a22_b} = tb_out;

	// stage 11: rounded dividends
	logic [DV_W-1:0] num0_s11, num1_s11;
	logic [s2es_pkg::ROOT_W-1:0] den_s11;
	logic [TD_W-1:0] td_s11;
	always_ff @(posedge clk) begin
		if (en) begin
			num0_s11 <= (DV_W'(nx_b) << FR) + DV_W'(rnorm >> 1);
			num1_s11 <= (DV_W'(nz_b) << FR) + DV_W'(rnorm >> 1);
			den_s11 <= rnorm;
			td_s11 <= {rot_b, neg_b, swp_b, a11_b, a12_b, a22_b};
		end
	end

	logic [QW-1:0] cq, sq;
	logic [TD_W-1:0] td_out;
	logic neg_d, swp_d, rot_d;
	logic signed [W-1:0] a11_d, a12_d, a22_d;

	s2es_div_pipe #(.N_W(s2es_pkg::ROOT_W), .Q_W(QW), .TAG_W(TD_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s11), .den(den_s11),
		.num0(num0_s11), .num1(num1_s11), .tag_in(td_s11),
		.out_valid(vd), .quo0(cq), .quo1(sq), .tag_out(td_out)
	);
	assign {rot_d, neg_d, swp_d, a11_d, a12_d, a22_d} = td_out;

	// stage 12: clamp and place signs
	s2es_pkg::vec_t cm, sm;
	s2es_pkg::vec_t c_s12, s_s12;
	logic signed [W-1:0] a11_s12, a12_s12, a22_s12;
	logic rot_s12;

	always_comb begin
		cm = $signed(VW'(cq));
		sm = $signed(VW'(sq));
		if (cm > s2es_pkg::ONE_Q30) begin
			cm = s2es_pkg::ONE_Q30;
		end
		if (sm > s2es_pkg::ONE_Q30) begin
			sm = s2es_pkg::ONE_Q30;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (swp_d) begin
				s_s12 <= sm;
				c_s12 <= neg_d ? cm : -cm;
			end else begin
				c_s12 <= cm;
				s_s12 <= neg_d ? sm : -sm;
			end
			a11_s12 <= a11_d;
			a12_s12 <= a12_d;
			a22_s12 <= a22_d;
			rot_s12 <= rot_d;
		end
	end

	// stage 13: rotation products
	logic signed [2*VW-1:0] pcc_s13, pss_s13, pcs_s13;
	s2es_pkg::vec_t c_s13, s_s13;
	logic signed [W-1:0] a11_s13, a12_s13, a22_s13;
	logic rot_s13;
	always_ff @(posedge clk) begin
		if (en) begin
			pcc_s13 <= c_s12 * c_s12;
			pss_s13 <= s_s12 * s_s12;
			pcs_s13 <= c_s12 * s_s12;
			c_s13 <= c_s12;
			s_s13 <= s_s12;
			a11_s13 <= a11_s12;
			a12_s13 <= a12_s12;
			a22_s13 <= a22_s12;
			rot_s13 <= rot_s12;
		end
	end

	// stage 14: round to Q30
	s2es_pkg::vec_t cc_s14, ss_s14, cs_s14, c_s14, s_s14;
	logic signed [W-1:0] a11_s14, a12_s14, a22_s14;
	logic rot_s14;
	always_ff @(posedge clk) begin
		if (en) begin
			cc_s14 <= VW'((pcc_s13 + RND_P) >>> FR);
			ss_s14 <= VW'((pss_s13 + RND_P) >>> FR);
			cs_s14 <= VW'((pcs_s13 + RND_P) >>> FR);
			c_s14 <= c_s13;
			s_s14 <= s_s13;
			a11_s14 <= a11_s13;
			a12_s14 <= a12_s13;
			a22_s14 <= a22_s13;
			rot_s14 <= rot_s13;
		end
	end

	// stage 15: entry products
	logic signed [PW-1:0] p1_s15, p2_s15, p3_s15, p4_s15, p5_s15;
	s2es_pkg::vec_t c_s15, s_s15;
	logic signed [W-1:0] a11_s15, a22_s15;
	logic rot_s15;
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s15 <= cc_s14 * a11_s14;
			p2_s15 <= cs_s14 * a12_s14;
			p3_s15 <= ss_s14 * a22_s14;
			p4_s15 <= ss_s14 * a11_s14;
			p5_s15 <= cc_s14 * a22_s14;
			c_s15 <= c_s14;
			s_s15 <= s_s14;
			a11_s15 <= a11_s14;
			a22_s15 <= a22_s14;
			rot_s15 <= rot_s14;
		end
	end

	// stage 16: diagonal sums
	logic signed [FW-1:0] f_s16, g_s16;
	s2es_pkg::vec_t c_s16, s_s16;
	logic signed [W-1:0] a11_s16, a22_s16;
	logic rot_s16;
	always_ff @(posedge clk) begin
		if (en) begin
			f_s16 <= FW'(p1_s15) - (FW'(p2_s15) <<< 1) + FW'(p3_s15);
			g_s16 <= FW'(p4_s15) + (FW'(p2_s15) <<< 1) + FW'(p5_s15);
			c_s16 <= c_s15;
			s_s16 <= s_s15;
			a11_s16 <= a11_s15;
			a22_s16 <= a22_s15;
			rot_s16 <= rot_s15;
		end
	end

	// stage 17: round, select, saturate
	logic signed [LX-1:0] l1, l2;
	s2es_pkg::eig_t eig_first_s17, eig_second_s17;
	s2es_pkg::vec_t vc_s17, vs_s17;

	always_comb begin
		if (rot_s16) begin
			l1 = LX'((f_s16 + RND_F) >>> FR);
			l2 = LX'((g_s16 + RND_F) >>> FR);
		end else begin
			l1 = LX'(a11_s16);
			l2 = LX'(a22_s16);
		end
		if (l1 > EMAX) begin
			l1 = EMAX;
		end
		if (l1 < EMIN) begin
			l1 = EMIN;
		end
		if (l2 > EMAX) begin
			l2 = EMAX;
		end
		if (l2 < EMIN) begin
			l2 = EMIN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eig_first_s17 <= s2es_pkg::EIG_W'(l1);
			eig_second_s17 <= s2es_pkg::EIG_W'(l2);
			vc_s17 <= rot_s16 ? c_s16 : s2es_pkg::ONE_Q30;
			vs_s17 <= rot_s16 ? s_s16 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= va;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= vb;
			v_s12 <= vd;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
		end
	end

	assign eig.valid = v_s17;
	assign eig.eig_first = eig_first_s17;
	assign eig.eig_second = eig_second_s17;
	assign eig.vec_11 = vc_s17;
	assign eig.vec_22 = vc_s17;
	assign eig.vec_21 = vs_s17;
	assign eig.vec_12 = -vs_s17;

`ifndef NO_ASSERTIONS
	a_vec_shape: assert property (@(posedge clk) disable iff (!arst_n)
		eig.valid |-> (eig.vec_11 == eig.vec_22) && (eig.vec_12 == -eig.vec_21))
		else $error("eigenvector matrix is not a rotation");
	a_vec_range: assert property (@(posedge clk) disable iff (!arst_n)
		eig.valid |-> (eig.vec_11 <= s2es_pkg::ONE_Q30) && (eig.vec_11 >= -s2es_pkg::ONE_Q30)
			&& (eig.vec_21 <= s2es_pkg::ONE_Q30) && (eig.vec_21 >= -s2es_pkg::ONE_Q30))
		else $error("rotation entry out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s16 && !en |=> v_s16)
		else $error("pipeline lost a transaction during a stall");
`endif
endmodule
`default_nettype wire

// File: rtl/core/s2es_isqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with side tag.
`default_nettype none
module s2es_isqrt_pipe #(
	parameter int RAD_W = 64,
	parameter int TAG_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     rad,
	input  logic [TAG_W-1:0]     tag_in,
	output logic                 out_valid,
	output logic [RAD_W/2-1:0]   root,
	output logic [TAG_W-1:0]     tag_out
);
	localparam int RT_W = RAD_W / 2;
	localparam int REM_W = RT_W + 2;

	logic [REM_W-1:0] rem_s  [RT_W];
	logic [RT_W-1:0]  root_s [RT_W];
	logic [RAD_W-1:0] rad_s  [RT_W];
	logic [TAG_W-1:0] tag_s  [RT_W];
	logic             vld_s  [RT_W];

	for (genvar i = 0; i < RT_W; i++) begin : g_stage
		logic [REM_W-1:0] p_rem;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		logic [RT_W-1:0]  p_root;
		logic [RAD_W-1:0] p_rad;
		logic [TAG_W-1:0] p_tag;
		logic             p_vld;
		logic             ge;
		if (i == 0) begin : g_first
			assign p_rem = '0;
			assign p_root = '0;
			assign p_rad = rad;
			assign p_tag = tag_in;
			assign p_vld = in_valid;
		end else begin : g_next
			assign p_rem = rem_s[i-1];
			assign p_root = root_s[i-1];
			assign p_rad = rad_s[i-1];
			assign p_tag = tag_s[i-1];
			assign p_vld = vld_s[i-1];
		end
		assign cur = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
		assign trial = {p_root, 2'b01};
		assign ge = (cur >= trial);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= p_vld;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? (cur - trial) : cur;
				root_s[i] <= {p_root[RT_W-2:0], ge};
				rad_s[i] <= p_rad << 2;
				tag_s[i] <= p_tag;
			end
		end
	end

	assign out_valid = vld_s[RT_W-1];
	assign root = root_s[RT_W-1];
	assign tag_out = tag_s[RT_W-1];
endmodule
`default_nettype wire

// File: rtl/core/s2es_div_pipe.sv
// Pipelined restoring divider: two dividends over one divisor, one bit per stage.
`default_nettype none
module s2es_div_pipe #(
	parameter int N_W = 32,
	parameter int Q_W = 31,
	parameter int TAG_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [N_W-1:0]       den,
	input  logic [Q_W+N_W-2:0]   num0,
	input  logic [Q_W+N_W-2:0]   num1,
	input  logic [TAG_W-1:0]     tag_in,
	output logic                 out_valid,
	output logic [Q_W-1:0]       quo0,
	output logic [Q_W-1:0]       quo1,
	output logic [TAG_W-1:0]     tag_out
);
	localparam int R_W = N_W + 1;

	logic [R_W-1:0]   rem0_s [Q_W];
	logic [R_W-1:0]   rem1_s [Q_W];
	logic [Q_W-1:0]   lo0_s  [Q_W];
	logic [Q_W-1:0]   lo1_s  [Q_W];
	logic [Q_W-1:0]   q0_s   [Q_W];
	logic [Q_W-1:0]   q1_s   [Q_W];
	logic [N_W-1:0]   den_s  [Q_W];
	logic [TAG_W-1:0] tag_s  [Q_W];
	logic             vld_s  [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [R_W-1:0]   p_rem0;
		logic [R_W-1:0]   p_rem1;
		logic [Q_W-1:0]   p_lo0;
		logic [Q_W-1:0]   p_lo1;
		logic [Q_W-1:0]   p_q0;
		logic [Q_W-1:0]   p_q1;
		logic [N_W-1:0]   p_den;
		logic [TAG_W-1:0] p_tag;
		logic             p_vld;
		logic [R_W-1:0]   cur0;
		logic [R_W-1:0]   cur1;
		logic [R_W-1:0]   dx;
		logic             ge0;
		logic             ge1;
		if (i == 0) begin : g_first
			assign p_rem0 = R_W'(num0[Q_W+N_W-2:Q_W]);
			assign p_rem1 = R_W'(num1[Q_W+N_W-2:Q_W]);
			assign p_lo0 = num0[Q_W-1:0];
			assign p_lo1 = num1[Q_W-1:0];
			assign p_q0 = '0;
			assign p_q1 = '0;
			assign p_den = den;
			assign p_tag = tag_in;
			assign p_vld = in_valid;
		end else begin : g_next
			assign p_rem0 = rem0_s[i-1];
			assign p_rem1 = rem1_s[i-1];
			assign p_lo0 = lo0_s[i-1];
			assign p_lo1 = lo1_s[i-1];
			assign p_q0 = q0_s[i-1];
			assign p_q1 = q1_s[i-1];
			assign p_den = den_s[i-1];
			assign p_tag = tag_s[i-1];
			assign p_vld = vld_s[i-1];
		end
		assign dx = {1'b0, p_den};
		assign cur0 = {p_rem0[N_W-1:0], p_lo0[Q_W-1]};
		assign cur1 = {p_rem1[N_W-1:0], p_lo1[Q_W-1]};
		assign ge0 = (cur0 >= dx);
		assign ge1 = (cur1 >= dx);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= p_vld;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem0_s[i] <= ge0 ? (cur0 - dx) : cur0;
				rem1_s[i] <= ge1 ? (cur1 - dx) : cur1;
				lo0_s[i] <= p_lo0 << 1;
				lo1_s[i] <= p_lo1 << 1;
				q0_s[i] <= {p_q0[Q_W-2:0], ge0};
				q1_s[i] <= {p_q1[Q_W-2:0], ge1};
				den_s[i] <= p_den;
				tag_s[i] <= p_tag;
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo0 = q0_s[Q_W-1];
	assign quo1 = q1_s[Q_W-1];
	assign tag_out = tag_s[Q_W-1];
endmodule
`default_nettype wire

// File: verif/s2es_checker.sv
// Checker of the eigen solver: predicts each matrix result and compares it with the block.
`timescale 1ns / 100ps
module s2es_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [s2es_pkg::CHOP_W-1:0] cfg_wdata,
	s2es_mat_if                         mat,
	s2es_eig_if                         eig,
	output int                          fail_count,
	output int                          pending
);
	typedef struct packed {
		s2es_pkg::eig_t first;
		s2es_pkg::eig_t second;
		s2es_pkg::vec_t v11;
		s2es_pkg::vec_t v12;
		s2es_pkg::vec_t v21;
		s2es_pkg::vec_t v22;
	} eig_res_t;

	localparam longint EIG_HI = (longint'(1) <<< 33) - 1;
	localparam longint EIG_LO = -(longint'(1) <<< 33);

	eig_res_t expected_q[$];
	logic [s2es_pkg::CHOP_W-1:0] chop;

	function automatic logic [63:0] mag(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] isqrt64(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint rnd30(longint v);
		return (v + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint sat_eig(longint v);
		if (v > EIG_HI) return EIG_HI;
		if (v < EIG_LO) return EIG_LO;
		return v;
	endfunction

	function automatic eig_res_t solve_matrix(logic signed [31:0] a11, logic signed [31:0] a12,
			logic signed [31:0] a22, logic [s2es_pkg::CHOP_W-1:0] sh);
		longint x11, x12, x22, l1, l2, c, s, d, mu2, xx, zz, cm, sm, cc, ss, cs, f, g;
		logic [63:0] ad, ab, m, r0, q, hh, lim, ax, az, nx, nz, r;
		int k;
		eig_res_t res;
		x11 = a11;
		x12 = a12;
		x22 = a22;
		l1 = x11;
		l2 = x22;
		c = 64'sd1073741824;
		s = 0;
		if ((mag(x12) << sh) < mag(x11) + mag(x22)) x12 = 0;
		if (x12 != 0) begin
			d = x11 - x22;
			ad = mag(d);
			ab = mag(x12);
			m = ((ad * ad) >> 2) + ab * ab;
			r0 = isqrt64(m);
			q = r0 * r0 + r0;
			hh = 2 * r0 + ((ad[0] ? (q <= m) : (q < m)) ? 64'd1 : 64'd0);
			mu2 = 2 * x22 + d + (d >= 0 ? -$signed(hh) : $signed(hh));
			lim = mag(x11) + mag(x12);
			k = int'(sh) + 1;
			if (lim <= (64'hFFFF_FFFF_FFFF_FFFF >> k) && mag(mu2) > (lim << k)) mu2 = 0;
			xx = 2 * x11 - mu2;
			zz = 2 * x12;
			ax = mag(xx);
			az = mag(zz);
			nx = ax;
			nz = az;
			while (((nx | nz) >> 31) != 0) begin
				nx = nx >> 1;
				nz = nz >> 1;
			end
			r = isqrt64(nx * nx + nz * nz);
			cm = $signed(((nx << 30) + (r >> 1)) / r);
			sm = $signed(((nz << 30) + (r >> 1)) / r);
			if (cm > 64'sd1073741824) cm = 64'sd1073741824;
			if (sm > 64'sd1073741824) sm = 64'sd1073741824;
			if (az > ax) begin
				s = sm;
				c = ((xx < 0) != (zz < 0)) ? cm : -cm;
			end else begin
				c = cm;
				s = ((xx < 0) != (zz < 0)) ? sm : -sm;
			end
			cc = rnd30(c * c);
			ss = rnd30(s * s);
			cs = rnd30(c * s);
			f = cc * x11 - 2 * cs * x12 + ss * x22;
			g = ss * x11 + 2 * cs * x12 + cc * x22;
			l1 = rnd30(f);
			l2 = rnd30(g);
		end
		l1 = sat_eig(l1);
		l2 = sat_eig(l2);
		res.first = l1[s2es_pkg::EIG_W-1:0];
		res.second = l2[s2es_pkg::EIG_W-1:0];
		res.v11 = c[s2es_pkg::VEC_W-1:0];
		res.v12 = 32'(-s);
		res.v21 = s[s2es_pkg::VEC_W-1:0];
		res.v22 = c[s2es_pkg::VEC_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		eig_res_t want;
		eig_res_t got;
		if (!arst_n) begin
			chop = s2es_pkg::CHOP_RESET;
			fail_count = 0;
			pending = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) chop = cfg_wdata;
			if (mat.valid && mat.ready)
				expected_q.push_back(solve_matrix(mat.a11, mat.a12, mat.a22, chop));
			if (eig.valid && eig.ready) begin
				got = {eig.eig_first, eig.eig_second, eig.vec_11, eig.vec_12,
					eig.vec_21, eig.vec_22};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result transaction: %h", got);
				end else begin
					want = expected_q.pop_front();
					if (want !== got) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: expected %0d %0d %0d %0d %0d %0d",
								want.first, want.second, want.v11, want.v12, want.v21, want.v22);
							$display("          actual   %0d %0d %0d %0d %0d %0d",
								got.first, got.second, got.v11, got.v12, got.v21, got.v22);
						end
					end
				end
			end
			pending = expected_q.size();
		end
	end
endmodule

// File: verif/testbench.sv
// Top of the eigen solver testbench: clock, reset, matrix stimulus, result stalls and verdict.
`timescale 1ns / 100ps
module testbench;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [s2es_pkg::CHOP_W-1:0] cfg_wdata;
	logic no_idle = 1'b0;
	int fail_count;
	int pending;
	int cycles = 0;
	int stall_left = 0;
	logic [s2es_pkg::CHOP_W-1:0] chop_now = s2es_pkg::CHOP_RESET;

	s2es_mat_if #(.DATA_WIDTH(32)) mat_ch ();
	s2es_eig_if eig_ch ();

	symmetric_2x2_eigen_solver #(.DATA_WIDTH(32)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mat(mat_ch), .eig(eig_ch)
	);

	s2es_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mat(mat_ch), .eig(eig_ch), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eig_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (no_idle) begin
			eig_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			eig_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			eig_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			eig_ch.ready <= 1'b1;
		end
	end

	task automatic send_matrix(logic signed [31:0] a11, logic signed [31:0] a12,
			logic signed [31:0] a22);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			mat_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		mat_ch.valid <= 1'b1;
		mat_ch.a11 <= a11;
		mat_ch.a12 <= a12;
		mat_ch.a22 <= a22;
		@(posedge clk);
		while (!mat_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		mat_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_chop(logic [s2es_pkg::CHOP_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		chop_now = v;
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $signed($urandom_range(0, 4000)) - 2000;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_random();
		logic signed [31:0] a11, a12, a22;
		a11 = $urandom();
		a12 = $urandom();
		a22 = $urandom();
		case ($urandom_range(0, 9))
			4: begin
				a11 = $signed($urandom_range(0, 2000)) - 1000;
				a12 = $signed($urandom_range(0, 2000)) - 1000;
				a22 = $signed($urandom_range(0, 2000)) - 1000;
			end
			5: a12 = a12 >>> $urandom_range(0, 31);
			6: begin
				a11 = rand_word();
				a12 = rand_word();
				a22 = rand_word();
			end
			7: a22 = a11;
			8: begin
				a11 = $urandom_range(0, 32'h3FFF_FFFF);
				a22 = 0;
				a12 = (a11 >>> chop_now) + $signed($urandom_range(0, 2)) - 1;
			end
			9: a12 = $signed(a12) >>> $urandom_range(8, 20);
			default: ;
		endcase
		send_matrix(a11, a12, a22);
	endtask

	initial begin
		logic [s2es_pkg::CHOP_W-1:0] chops [7];
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		mat_ch.valid <= 1'b0;
		mat_ch.a11 <= '0;
		mat_ch.a12 <= '0;
		mat_ch.a22 <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_matrix(0, 0, 0);
		send_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_matrix(32'h8000_0000, 0, 32'h7FFF_FFFF);
		send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_matrix(1, 1, 1);
		send_matrix(-1, -1, -1);
		send_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_matrix(32'h0080_0000, 1, 0);
		send_matrix(32'h0080_0001, 1, 0);
		send_matrix(0, 1, 32'h0080_0000);
		send_matrix(0, 32'h0001_0000, 0);
		send_matrix(32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
		send_matrix(32'h0001_0000, -32'sh0001_0000, 32'h0003_0000);
		send_matrix(32'h0002_0001, 32'h0000_8000, 0);
		send_matrix(-32'sh0005_0000, 32'h0004_0000, 32'h0005_0000);
		send_matrix(0, 1, 1);
		send_matrix(32'h4000_0000, 32'h4000_0000, -32'sh4000_0000);
		send_matrix(32'h7FFF_FFFF, 1, 32'h8000_0000);
		drain();

		chops = '{5'd0, 5'd31, 5'd1, 5'd0, 5'd12, 5'd31, 5'd0};
		for (int p = 0; p < 7; p++) begin
			write_chop(p == 4 ? s2es_pkg::CHOP_W'($urandom_range(2, 30)) : chops[p]);
			if (p == 6) no_idle <= 1'b1;
			repeat (165) send_random();
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/s2es_pkg.sv
rtl/core/s2es_mat_if.sv
rtl/core/s2es_eig_if.sv
rtl/core/s2es_isqrt_pipe.sv
rtl/core/s2es_div_pipe.sv
rtl/core/symmetric_2x2_eigen_solver.sv
verif/s2es_checker.sv
verif/testbench.sv
